FILE: sv/sobel_pkg.sv
// shared constants, types and register codes for the sobel edge magnitude block
package sobel_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int MIN_SIZE     = 3;

    localparam int PIX_W  = 8;                       // pixel port width
    localparam int CFG_W  = 11;                      // width / height register width
    localparam int ADDR_W = $clog2(MAX_WIDTH);       // column counter and line buffer address
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);    // row counter
    localparam int MAG_W  = 11;                      // edge magnitude width
    localparam int SUM_W  = PIXEL_BITS + 2;          // weighted 1,2,1 sum

    // apb register map, index taken from paddr[2]
    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    // per-request position flags from the raster counters
    typedef struct packed
    {
        logic inner;
        logic last;
    } pos_t;

endpackage

FILE: sv/sobel_edge_magnitude_3x3.sv
// top level of the 3x3 sobel edge magnitude block with apb register port
// Sobel edge magnitude over a raster pixel stream. Pixels enter one per request in raster
// order; each request yields exactly one result, |Gx|+|Gy| (0..2040) for the 3x3 window
// centred one row up and one column left of that pixel, with interior low and magnitude
// zero when that centre sits on the frame border. frame_start forces the pixel to row 0,
// column 0; after the last pixel of a frame (flagged by frame_end) the counters wrap, so
// frame_start is optional on later frames. Throughput is one request per clock while the
// result side is not stalled; a request loads the registered read of the line buffer
// memories and stage 1, then the result register once it is free or its result leaves.
// Two 1024 x 8 line buffers hold the previous rows and need no clearing after reset,
// since stale contents only reach border results. image_width (address 0) and
// image_height (address 4) saturate to 3..1024 and reset to 640 x 480; change them only
// while the stream is idle.
module sobel_edge_magnitude_3x3
(
    input  logic                        clk,
    input  logic                        rst_n,
    // apb register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // pixel request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sobel_pkg::PIX_W-1:0] pixel,
    input  logic                        frame_start,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sobel_pkg::MAG_W-1:0] edge_magnitude,
    output logic                        interior,
    output logic                        frame_end
);
    import sobel_pkg::*;

    // config registers
    logic [CFG_W-1:0]      width_reg;
    logic [CFG_W-1:0]      height_reg;
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;

    // pipeline control
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  accept;
    logic                  out_ld;

    // stage 1 payload, alongside the line buffer read data
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    pos_t                  s1_pos_reg;

    // result register
    logic [MAG_W-1:0]      mag_reg;
    logic                  interior_reg;
    logic                  frame_end_reg;

    logic [ADDR_W-1:0]     col_idx;
    pos_t                  pos;
    logic [PIXEL_BITS-1:0] pix_in;
    logic [PIXEL_BITS-1:0] col_top;
    logic [PIXEL_BITS-1:0] col_mid;
    logic [MAG_W-1:0]      mag;

    // ------------------------------------------------------------------
    // apb: zero wait states, register picked by paddr[2]
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // two stage flow: stage 1 waits on the memory read, then the result
    // register; stage 1 moves whenever the result register is free or leaving
    // ------------------------------------------------------------------
    assign out_ld   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_ld;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (out_ld)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_ld)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pix_in = pixel[PIXEL_BITS-1:0];

    // raster position of the incoming pixel
    sobel_raster_cnt u_cnt
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .frame_start  (frame_start),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col_idx      (col_idx),
        .pos          (pos)
    );

    // column above the pixel from the two previous rows
    sobel_line_buf u_lbuf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .addr    (col_idx),
        .pix_in  (pix_in),
        .col_top (col_top),
        .col_mid (col_mid)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pix_in;
            s1_pos_reg <= pos;
        end
    end

    // window shift and gradient, one request per shift
    sobel_window u_win
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (out_ld),
        .col_top  (col_top),
        .col_mid  (col_mid),
        .col_bot  (s1_pix_reg),
        .inner    (s1_pos_reg.inner),
        .mag      (mag)
    );

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            mag_reg       <= mag;
            interior_reg  <= s1_pos_reg.inner;
            frame_end_reg <= s1_pos_reg.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign edge_magnitude = mag_reg;
    assign interior       = interior_reg;
    assign frame_end      = frame_end_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // border results carry no magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !interior |-> edge_magnitude == '0)
    else $error("border result with nonzero magnitude");

    // input only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result side is free");

    // a width write lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && cfg_idx == REG_IMAGE_WIDTH |=> width_reg == $past(pwdata[CFG_W-1:0]))
    else $error("width register write lost");

endmodule

FILE: sv/sobel_raster_cnt.sv
// raster column and row counters with border and frame end decode
module sobel_raster_cnt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         frame_start,
    input  logic [sobel_pkg::CFG_W-1:0]  image_width,
    input  logic [sobel_pkg::CFG_W-1:0]  image_height,
    output logic [sobel_pkg::ADDR_W-1:0] col_idx,
    output sobel_pkg::pos_t              pos
);
    import sobel_pkg::*;

    logic [ADDR_W-1:0] col_reg;
    logic [ADDR_W-1:0] col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ADDR_W-1:0] col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [CFG_W-1:0]  w_sat;
    logic [CFG_W-1:0]  h_sat;
    logic [CFG_W-1:0]  w_m1;
    logic [CFG_W-1:0]  h_m1;
    logic              last_col;
    logic              last_row;

    // saturate sizes to the supported range
    always_comb
    begin
        if (image_width < CFG_W'(MIN_SIZE))
            w_sat = CFG_W'(MIN_SIZE);
        else if (image_width > CFG_W'(MAX_WIDTH))
            w_sat = CFG_W'(MAX_WIDTH);
        else
            w_sat = image_width;

        if (image_height < CFG_W'(MIN_SIZE))
            h_sat = CFG_W'(MIN_SIZE);
        else if (image_height > CFG_W'(HEIGHT_LIMIT))
            h_sat = CFG_W'(HEIGHT_LIMIT);
        else
            h_sat = image_height;
    end

    assign w_m1 = w_sat - CFG_W'(1);
    assign h_m1 = h_sat - CFG_W'(1);

    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;

    assign last_col = CFG_W'(col_cur) >= w_m1;
    assign last_row = CFG_W'(row_cur) >= h_m1;

    assign col_idx   = col_cur;
    assign pos.inner = (row_cur >= ROW_W'(2)) && (col_cur >= ADDR_W'(2))
                    && (CFG_W'(row_cur) <= h_m1) && (CFG_W'(col_cur) <= w_m1);
    assign pos.last  = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_cur + ROW_W'(1);
            end
            else
            begin
                col_next = col_cur + ADDR_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: sv/sobel_line_buf.sv
// two line buffer memories with registered reads and same-address forwarding
module sobel_line_buf
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [sobel_pkg::ADDR_W-1:0]     addr,
    input  logic [sobel_pkg::PIXEL_BITS-1:0] pix_in,
    output logic [sobel_pkg::PIXEL_BITS-1:0] col_top,
    output logic [sobel_pkg::PIXEL_BITS-1:0] col_mid
);
    import sobel_pkg::*;

    logic [PIXEL_BITS-1:0] mem_one [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] mem_two [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] one_rd_reg;
    logic [PIXEL_BITS-1:0] two_rd_reg;
    logic [PIXEL_BITS-1:0] fwd_data_reg;
    logic [ADDR_W-1:0]     wr_addr_reg;
    logic                  wr_pend_reg;
    logic                  fwd_reg;

    // row one up: read old entry, then store the new pixel
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            one_rd_reg    <= mem_one[addr];
            mem_one[addr] <= pix_in;
        end
    end

    // row two up: written late, through a registered address and pending flag, with the entry just read from row one up
    always_ff @(posedge clk)
    begin
        if (rd_en)
            two_rd_reg <= mem_two[addr];
        if (wr_pend_reg)
            mem_two[wr_addr_reg] <= one_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            wr_addr_reg  <= addr;
            fwd_data_reg <= one_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pend_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= rd_en;
            if (rd_en)
                fwd_reg <= wr_pend_reg && (wr_addr_reg == addr);
        end
    end

    // read of an entry whose late write lands on the same edge
    assign col_top = fwd_reg ? fwd_data_reg : two_rd_reg;
    assign col_mid = one_rd_reg;

endmodule

FILE: sv/sobel_window.sv
// 3x3 pixel window and l1 sobel gradient magnitude
module sobel_window
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             shift_en,
    input  logic [sobel_pkg::PIXEL_BITS-1:0] col_top,
    input  logic [sobel_pkg::PIXEL_BITS-1:0] col_mid,
    input  logic [sobel_pkg::PIXEL_BITS-1:0] col_bot,
    input  logic                             inner,
    output logic [sobel_pkg::MAG_W-1:0]      mag
);
    import sobel_pkg::*;

    // layout row*3 + col, row 0 on top
    logic [PIXEL_BITS-1:0] win_reg  [9];
    logic [PIXEL_BITS-1:0] win_next [9];
    logic [SUM_W-1:0]      top_sum;
    logic [SUM_W-1:0]      bot_sum;
    logic [SUM_W-1:0]      lft_sum;
    logic [SUM_W-1:0]      rgt_sum;
    logic [SUM_W-1:0]      gy_abs;
    logic [SUM_W-1:0]      gx_abs;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3 + 0] = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = col_top;
        win_next[5] = col_mid;
        win_next[8] = col_bot;
    end

    assign top_sum = SUM_W'(win_next[0]) + {1'b0, win_next[1], 1'b0} + SUM_W'(win_next[2]);
    assign bot_sum = SUM_W'(win_next[6]) + {1'b0, win_next[7], 1'b0} + SUM_W'(win_next[8]);
    assign lft_sum = SUM_W'(win_next[0]) + {1'b0, win_next[3], 1'b0} + SUM_W'(win_next[6]);
    assign rgt_sum = SUM_W'(win_next[2]) + {1'b0, win_next[5], 1'b0} + SUM_W'(win_next[8]);

    assign gy_abs = (top_sum >= bot_sum) ? top_sum - bot_sum : bot_sum - top_sum;
    assign gx_abs = (lft_sum >= rgt_sum) ? lft_sum - rgt_sum : rgt_sum - lft_sum;

    assign mag = inner ? MAG_W'(gy_abs) + MAG_W'(gx_abs) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (shift_en)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= win_next[k];
        end
    end

endmodule
